### rtl/core/ble_pkg.sv
// Shared types, codes and defaults for the bounded list engine.
package ble_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam logic [2:0] CMD_INSERT_FRONT = 3'd0;
   localparam logic [2:0] CMD_INSERT_BACK  = 3'd1;
   localparam logic [2:0] CMD_DELETE_FRONT = 3'd2;
   localparam logic [2:0] CMD_DELETE_BACK  = 3'd3;
   localparam logic [2:0] CMD_DELETE_AT    = 3'd4;
   localparam logic [2:0] CMD_DISPLAY      = 3'd5;

   localparam logic [2:0] STATUS_DONE     = 3'd0;
   localparam logic [2:0] STATUS_EMPTY    = 3'd1;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd2;
   localparam logic [2:0] STATUS_NOTHING  = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;
   localparam logic [2:0] STATUS_ELEMENT  = 3'd5;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH_FRONT,
      ACT_PUSH_BACK,
      ACT_POP_AT,
      ACT_ROTATE
   } chain_action_type;

   typedef struct packed {
      chain_action_type   action;
      logic signed [31:0] value;
   } chain_ctl_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_FROM_HEAD
   } cell_op_type;

endpackage

### rtl/core/ble_cell.sv
// One storage cell of the list chain.
module ble_cell (
   input  logic               clock,
   input  ble_pkg::cell_op_type op,
   input  logic signed [31:0] load_data,
   input  logic signed [31:0] left_data,
   input  logic signed [31:0] right_data,
   input  logic signed [31:0] head_data,
   output logic signed [31:0] data_q
);
   import ble_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      case (op)
         CELL_HOLD:       data_in = data_ff;
         CELL_LOAD:       data_in = load_data;
         CELL_FROM_LEFT:  data_in = left_data;
         CELL_FROM_RIGHT: data_in = right_data;
         CELL_FROM_HEAD:  data_in = head_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

### rtl/core/ble_chain.sv
// Row of list cells with per-cell shift, load and rotate control.
module ble_chain #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  ble_pkg::chain_ctl_type ctl,
   input  logic [CNT_W-1:0]     count,
   input  logic [IDX_W-1:0]     pop_idx,
   output logic signed [31:0]   head_data
);
   import ble_pkg::*;

   logic signed [31:0] cell_q [DEPTH];

   assign head_data = cell_q[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] POS = CNT_W'(i);
      localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(i + 1);
      localparam logic [IDX_W-1:0] SLOT = IDX_W'(i);

      cell_op_type        op;
      logic signed [31:0] left_data;
      logic signed [31:0] right_data;

      if (i == 0) begin : g_left_edge
         assign left_data = ctl.value;
      end else begin : g_left_link
         assign left_data = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_right_edge
         assign right_data = cell_q[i];
      end else begin : g_right_link
         assign right_data = cell_q[i+1];
      end

      always_comb begin
         op = CELL_HOLD;
         case (ctl.action)
            ACT_PUSH_FRONT: op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
            ACT_PUSH_BACK:  op = (count == POS) ? CELL_LOAD : CELL_HOLD;
            ACT_POP_AT:     op = (SLOT >= pop_idx) ? CELL_FROM_RIGHT : CELL_HOLD;
            ACT_ROTATE: begin
               if (NEXT_POS < count) begin
                  op = CELL_FROM_RIGHT;
               end else if (NEXT_POS == count) begin
                  op = CELL_FROM_HEAD;
               end
            end
            default: op = CELL_HOLD;
         endcase
      end

      ble_cell u_cell (
         .clock      (clock),
         .op         (op),
         .load_data  (ctl.value),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_q[0]),
         .data_q     (cell_q[i])
      );
   end

endmodule

### rtl/core/bounded_list_engine.sv
// Top level of the bounded list engine: command decode, count, display walk, output beat.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall  command, value, position
//   rsp_      out        rsp_valid/rsp_stall  status, element, last
//
// Insert and delete commands give one beat each.
// Display gives one beat per stored element: the chain
// rotates its first count cells once per beat, so the head cell feeds every element.
// Reset clears the count, the state and the output valid; cell contents stay.
// A stalled output beat holds; no new command is taken until the beat slot frees.
module bounded_list_engine #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ble_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ble_pkg::rsp_payload_type rsp_payload
);
   import ble_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SHOW = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   chain_ctl_type     chain_ctl;
   logic [IDX_W-1:0]  pop_idx;
   logic signed [31:0] head_data;

   logic       slot_free;
   logic       req_take;
   logic [7:0] pos_ext;
   logic [7:0] end_pos;
   logic [6:0] pos_less;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign req_take  = req_valid && !req_stall;
   assign pos_ext   = {1'b0, req_payload.position};
   assign end_pos   = 8'(count_ff) + 8'd1;
   assign pos_less  = req_payload.position - 7'd1;

   always_comb begin
      chain_ctl.action = ACT_NONE;
      chain_ctl.value  = req_payload.value;
      pop_idx          = '0;
      count_in         = count_ff;
      remain_in        = remain_ff;
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_payload_in   = rsp_payload_ff;
      if (req_take) begin
         rsp_valid_in           = 1'b1;
         rsp_payload_in.status  = STATUS_DONE;
         rsp_payload_in.element = '0;
         rsp_payload_in.last    = 1'b1;
         case (req_payload.command)
            CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
               if (count_ff == FULL_COUNT) begin
                  rsp_payload_in.status = STATUS_FULL;
               end else begin
                  chain_ctl.action = (req_payload.command == CMD_INSERT_FRONT) ?
                                     ACT_PUSH_FRONT : ACT_PUSH_BACK;
                  count_in = count_ff + ONE;
               end
            end
            CMD_DELETE_FRONT: begin
               if (count_ff == '0) begin
                  rsp_payload_in.status = STATUS_EMPTY;
               end else begin
                  chain_ctl.action = ACT_POP_AT;
                  count_in = count_ff - ONE;
               end
            end
            CMD_DELETE_BACK: begin
               if (count_ff == '0) begin
                  rsp_payload_in.status = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - ONE;
               end
            end
            CMD_DELETE_AT: begin
               if (count_ff == '0) begin
                  rsp_payload_in.status = STATUS_EMPTY;
               end else if (req_payload.position < 7'd2) begin
                  chain_ctl.action = ACT_POP_AT;
                  count_in = count_ff - ONE;
               end else if (pos_ext > end_pos) begin
                  rsp_payload_in.status = STATUS_NOTFOUND;
               end else if (pos_ext == end_pos) begin
                  rsp_payload_in.status = STATUS_NOTHING;
               end else begin
                  chain_ctl.action = ACT_POP_AT;
                  pop_idx  = pos_less[IDX_W-1:0];
                  count_in = count_ff - ONE;
               end
            end
            CMD_DISPLAY: begin
               if (count_ff == '0) begin
                  rsp_payload_in.status = STATUS_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  remain_in    = count_ff;
                  state_in     = ST_SHOW;
               end
            end
            default: rsp_valid_in = 1'b0;
         endcase
      end else if ((state_ff == ST_SHOW) && slot_free) begin
         chain_ctl.action       = ACT_ROTATE;
         rsp_valid_in           = 1'b1;
         rsp_payload_in.status  = STATUS_ELEMENT;
         rsp_payload_in.element = head_data;
         rsp_payload_in.last    = (remain_ff == ONE);
         remain_in              = remain_ff - ONE;
         if (remain_ff == ONE) begin
            state_in = ST_IDLE;
         end
      end
   end

   ble_chain #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
   ) u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .count     (count_ff),
      .pop_idx   (pop_idx),
      .head_data (head_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above depth");

   a_show_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("display walk out of range");

   a_open_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> (rsp_payload.status == STATUS_ELEMENT))
      else $error("non-final beat that is not an element");

   a_show_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |=> (count_ff == $past(count_ff)))
      else $error("count changed during display");
`endif

endmodule
